[rtl/set_assoc_lru_cache_lookup_unit_defines.svh]
// Assertion macros for the set-associative LRU cache lookup unit
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define SALC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define SALC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/salc_pkg.sv]
// Package: constants, types and codes of the cache lookup unit
`default_nettype none

package salc_pkg;

  // set and way counts are powers of two
  localparam int MAX_SETS = 256;
  localparam int MAX_WAYS = 8;

  localparam int SET_BITS = $clog2(MAX_SETS);
  localparam int SET_W    = (SET_BITS < 1) ? 1 : SET_BITS;
  localparam int WAY_BITS = $clog2(MAX_WAYS);
  localparam int WAY_W    = (WAY_BITS < 1) ? 1 : WAY_BITS;
  localparam int META_DEPTH = 1 << SET_W;
  localparam int TAG_AW     = SET_W + WAY_W;
  localparam int TAG_DEPTH  = 1 << TAG_AW;

  // set_index_bits above 12 acts as 12, and never beyond the sets built
  localparam int SIB_LIMIT = 12;
  localparam int SIB_MAX   = (SET_BITS < SIB_LIMIT) ? SET_BITS : SIB_LIMIT;

  localparam int ADDR_W = 32;
  localparam int BLK_W  = 30;
  localparam int CNT_W  = 32;
  localparam int WAYO_W = 3;
  localparam int BYTE_OFFSET_BITS = 2;

  localparam int AGE_W = 3;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_SET_INDEX_BITS   = 2'd0;
  localparam logic [1:0] REG_WORD_OFFSET_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS_IN_USE      = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMPARE,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [MAX_WAYS-1:0]            valid;
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
  } meta_row_t;

  typedef struct packed {
    logic             clear;
    logic             step;
    logic [WAY_W-1:0] way;
    logic             valid;
    logic [AGE_W-1:0] age;
    logic [BLK_W-1:0] tag;
  } scan_req_t;

  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] hit_way;
    logic             free_found;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] victim_way;
  } scan_res_t;

endpackage

`default_nettype wire

[rtl/salc_meta_ram.sv]
// Per-set valid and age row store, with a clearing sweep after reset
`default_nettype none

module salc_meta_ram (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       rd_en,
  input  wire logic [salc_pkg::SET_W-1:0] rd_addr,
  output salc_pkg::meta_row_t             rd_data,
  input  wire logic                       wr_en,
  input  wire logic [salc_pkg::SET_W-1:0] wr_addr,
  input  wire salc_pkg::meta_row_t        wr_data,
  output logic                            clear_busy
);

  salc_pkg::meta_row_t mem [salc_pkg::META_DEPTH];
  logic [salc_pkg::SET_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_addr   <= '0;
    end else if (clear_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == salc_pkg::SET_W'(salc_pkg::META_DEPTH - 1)) begin
        clear_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/salc_tag_ram.sv]
// Block address store, one entry per line
`default_nettype none

module salc_tag_ram (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [salc_pkg::TAG_AW-1:0] rd_addr,
  output logic      [salc_pkg::BLK_W-1:0]  rd_data,
  input  wire logic                        wr_en,
  input  wire logic [salc_pkg::TAG_AW-1:0] wr_addr,
  input  wire logic [salc_pkg::BLK_W-1:0]  wr_data
);

  logic [salc_pkg::BLK_W-1:0] mem [salc_pkg::TAG_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/salc_way_unit.sv]
// Shared per-way unit: tag compare, first free way and oldest way, one way a cycle
`default_nettype none

module salc_way_unit (
  input  wire logic                       clk,
  input  wire salc_pkg::scan_req_t        req,
  input  wire logic [salc_pkg::BLK_W-1:0] block,
  output salc_pkg::scan_res_t             res
);

  logic [salc_pkg::AGE_W-1:0] best_age;
  logic                       match;

  assign match = req.valid && (req.tag == block);

  always_ff @(posedge clk) begin
    if (req.clear) begin
      res      <= '0;
      best_age <= '0;
    end else if (req.step) begin
      if (!res.hit && match) begin
        res.hit     <= 1'b1;
        res.hit_way <= req.way;
      end
      if (!res.free_found && !req.valid) begin
        res.free_found <= 1'b1;
        res.free_way   <= req.way;
      end
      // strict compare: ties keep the lower way
      if (req.age > best_age) begin
        best_age       <= req.age;
        res.victim_way <= req.way;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/set_assoc_lru_cache_lookup_unit.sv]
// Top level: set-associative cache lookup with LRU replacement
//
// Request channel: req_valid/req_stall carry one 32-bit byte_address a word.
// Response channel: rsp_valid/rsp_stall carry hit, way_used and the running,
// saturating hit_total and miss_total after that access.
// Configuration: APB-style registers set_index_bits (0x0), word_offset_bits
// (0x4) and ways_in_use (0x8); pready is tied high, reads return the values.
// One word is looked up at a time. The tag store is read and compared one
// way per cycle. req_stall is high while a word is in work.
// Reset clears the counters and registers, then a sweep clears the valid and
// age rows, one set a cycle; req_stall stays high meanwhile.
// The response sits in an output register: a new word may be accepted while
// it waits, but that word's result is held until rsp_stall drops.
// Register writes do not flush the cache.
`default_nettype none

module set_assoc_lru_cache_lookup_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [salc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [salc_pkg::PDATA_W-1:0] pwdata,
  output logic      [salc_pkg::PDATA_W-1:0] prdata,
  output logic                              pready,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [salc_pkg::ADDR_W-1:0]  byte_address,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic                              hit,
  output logic      [salc_pkg::WAYO_W-1:0]  way_used,
  output logic      [salc_pkg::CNT_W-1:0]   hit_total,
  output logic      [salc_pkg::CNT_W-1:0]   miss_total
);

  `include "set_assoc_lru_cache_lookup_unit_defines.svh"

  salc_pkg::state_t state, state_next;

  logic [3:0] set_index_bits;
  logic [2:0] word_offset_bits;
  logic [3:0] ways_in_use;

  logic                         cfg_wr;
  logic [1:0]                   cfg_idx;
  logic                         accept;
  logic                         clear_busy;
  logic                         fire;

  logic [3:0]                   sib_eff;
  logic [salc_pkg::SET_W-1:0]   set_mask;
  logic [4:0]                   shift_amt;
  logic [salc_pkg::ADDR_W-1:0]  byte_shift;
  logic [salc_pkg::BLK_W-1:0]   block_next;
  logic [4:0]                   ways_lim;

  logic [salc_pkg::BLK_W-1:0]   block_q;
  logic [salc_pkg::SET_W-1:0]   set_q;
  logic [salc_pkg::WAY_W-1:0]   ways_m1_q;
  logic [salc_pkg::WAY_W-1:0]   way_cnt;

  logic                         meta_rd_en;
  logic                         tag_rd_en;
  logic [salc_pkg::TAG_AW-1:0]  tag_rd_addr;
  logic [salc_pkg::BLK_W-1:0]   tag_q;
  salc_pkg::meta_row_t          meta_q;
  salc_pkg::meta_row_t          row_next;
  salc_pkg::scan_req_t          scan_req;
  salc_pkg::scan_res_t          scan_res;

  logic [salc_pkg::WAY_W-1:0]   w_sel;
  logic [3:0]                   limit;
  logic [salc_pkg::CNT_W-1:0]   hits_next;
  logic [salc_pkg::CNT_W-1:0]   misses_next;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits   <= '0;
      word_offset_bits <= '0;
      ways_in_use      <= 4'd1;
    end else if (cfg_wr) begin
      if (cfg_idx == salc_pkg::REG_SET_INDEX_BITS) begin
        set_index_bits <= pwdata[3:0];
      end
      if (cfg_idx == salc_pkg::REG_WORD_OFFSET_BITS) begin
        word_offset_bits <= pwdata[2:0];
      end
      if (cfg_idx == salc_pkg::REG_WAYS_IN_USE) begin
        ways_in_use <= pwdata[3:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      salc_pkg::REG_SET_INDEX_BITS:   prdata = salc_pkg::PDATA_W'(set_index_bits);
      salc_pkg::REG_WORD_OFFSET_BITS: prdata = salc_pkg::PDATA_W'(word_offset_bits);
      salc_pkg::REG_WAYS_IN_USE:      prdata = salc_pkg::PDATA_W'(ways_in_use);
      default:                        prdata = '0;
    endcase
  end

  // address split and clamps, taken at acceptance
  assign sib_eff    = (set_index_bits > 4'(salc_pkg::SIB_MAX)) ?
                      4'(salc_pkg::SIB_MAX) : set_index_bits;
  assign set_mask   = salc_pkg::SET_W'((32'd1 << sib_eff) - 32'd1);
  assign shift_amt  = 5'(word_offset_bits) + 5'(salc_pkg::BYTE_OFFSET_BITS);
  assign byte_shift = byte_address >> shift_amt;
  assign block_next = byte_shift[salc_pkg::BLK_W-1:0];
  assign ways_lim   = (ways_in_use == '0) ? 5'd1 :
                      ({1'b0, ways_in_use} > 5'(salc_pkg::MAX_WAYS)) ?
                      5'(salc_pkg::MAX_WAYS) : {1'b0, ways_in_use};

  assign req_stall = (state != salc_pkg::ST_IDLE) || clear_busy;
  assign accept    = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (accept) begin
      block_q   <= block_next;
      set_q     <= block_next[salc_pkg::SET_W-1:0] & set_mask;
      ways_m1_q <= salc_pkg::WAY_W'(ways_lim - 5'd1);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      salc_pkg::ST_IDLE:    if (accept) state_next = salc_pkg::ST_LOOKUP;
      salc_pkg::ST_LOOKUP:  state_next = salc_pkg::ST_COMPARE;
      salc_pkg::ST_COMPARE: if (way_cnt == ways_m1_q) state_next = salc_pkg::ST_UPDATE;
      salc_pkg::ST_UPDATE:  if (fire) state_next = salc_pkg::ST_IDLE;
      default:              state_next = salc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    meta_rd_en     = (state == salc_pkg::ST_LOOKUP);
    tag_rd_en      = (state == salc_pkg::ST_LOOKUP) || (state == salc_pkg::ST_COMPARE);
    tag_rd_addr    = (state == salc_pkg::ST_LOOKUP) ? {set_q, salc_pkg::WAY_W'(0)} :
                                                      {set_q, way_cnt + 1'b1};
    fire           = (state == salc_pkg::ST_UPDATE) && (!rsp_valid || !rsp_stall);
    scan_req.clear = (state == salc_pkg::ST_LOOKUP);
    scan_req.step  = (state == salc_pkg::ST_COMPARE);
    scan_req.way   = way_cnt;
    scan_req.valid = meta_q.valid[way_cnt];
    scan_req.age   = meta_q.age[way_cnt];
    scan_req.tag   = tag_q;
  end

  always_ff @(posedge clk) begin
    if (state == salc_pkg::ST_LOOKUP) begin
      way_cnt <= '0;
    end else if (state == salc_pkg::ST_COMPARE) begin
      way_cnt <= way_cnt + 1'b1;
    end
  end

  salc_meta_ram u_meta (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (meta_rd_en),
    .rd_addr    (set_q),
    .rd_data    (meta_q),
    .wr_en      (fire),
    .wr_addr    (set_q),
    .wr_data    (row_next),
    .clear_busy (clear_busy)
  );

  salc_tag_ram u_tag (
    .clk     (clk),
    .rd_en   (tag_rd_en),
    .rd_addr (tag_rd_addr),
    .rd_data (tag_q),
    .wr_en   (fire && !scan_res.hit),
    .wr_addr ({set_q, w_sel}),
    .wr_data (block_q)
  );

  salc_way_unit u_way (
    .clk   (clk),
    .req   (scan_req),
    .block (block_q),
    .res   (scan_res)
  );

  // replacement choice and age update of the set row
  always_comb begin
    priority if (scan_res.hit) begin
      w_sel = scan_res.hit_way;
    end else if (scan_res.free_found) begin
      w_sel = scan_res.free_way;
    end else begin
      w_sel = scan_res.victim_way;
    end
    limit    = scan_res.hit ? {1'b0, meta_q.age[w_sel]} : 4'd8;
    row_next = meta_q;
    for (int i = 0; i < salc_pkg::MAX_WAYS; i++) begin
      if (salc_pkg::WAY_W'(i) == w_sel) begin
        row_next.valid[i] = 1'b1;
        row_next.age[i]   = '0;
      end else if (salc_pkg::WAY_W'(i) <= ways_m1_q && meta_q.valid[i] &&
                   {1'b0, meta_q.age[i]} < limit && meta_q.age[i] != salc_pkg::AGE_MAX) begin
        row_next.age[i] = meta_q.age[i] + 1'b1;
      end
    end
  end

  assign hits_next   = (scan_res.hit && hit_total != '1) ? hit_total + 1'b1 : hit_total;
  assign misses_next = (!scan_res.hit && miss_total != '1) ? miss_total + 1'b1 : miss_total;

  // output register; the totals double as the running counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      hit_total  <= '0;
      miss_total <= '0;
    end else if (fire) begin
      rsp_valid  <= 1'b1;
      hit_total  <= hits_next;
      miss_total <= misses_next;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hit      <= scan_res.hit;
      way_used <= salc_pkg::WAYO_W'(w_sel);
    end
  end

  `SALC_ASSERT_NXT(a_busy_after_accept, accept, state == salc_pkg::ST_LOOKUP, "accept did not start a lookup")
  `SALC_ASSERT_IMP(a_stall_while_clearing, clear_busy, req_stall, "word accepted during clearing sweep")
  `SALC_ASSERT_NXT(a_result_loaded, fire, rsp_valid && state == salc_pkg::ST_IDLE, "update did not load a result")
  `SALC_ASSERT_IMP(a_hit_counted, rsp_valid && hit, hit_total != '0, "hit reported with zero hit total")
  `SALC_ASSERT_IMP(a_miss_counted, rsp_valid && !hit, miss_total != '0, "miss reported with zero miss total")

endmodule

`default_nettype wire
